// ===== sv/plist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional list: request and status
// codes, cell control and the sequencer states.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int GROUP_SIZE     = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     rd;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_EXEC  = 3'd1,
        S_GROUP = 3'd2,
        S_MERGE = 3'd3,
        S_DONE  = 3'd4
    } t_state;

endpackage
`default_nettype wire

// ===== sv/plist_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cell
// One list entry. Shifts up from its left neighbor on insert, down from its
// right neighbor on remove, and offers its old word on a read tap.
// ----------------------------------------------------------------------------
module plist_cell #(
    parameter int INDEX  = 0,
    parameter int CNT_W  = 7,
    parameter int WORD_W = 32
) (
    input  wire                     i_clk,
    input  plist_pkg::t_cell_ctrl   i_ctrl,
    input  wire  [CNT_W-1:0]        i_pos,
    input  wire  [WORD_W-1:0]       i_word,
    input  wire  [WORD_W-1:0]       i_left,
    input  wire  [WORD_W-1:0]       i_right,
    output logic [WORD_W-1:0]       o_data,
    output logic [WORD_W-1:0]       o_tap
);
    import plist_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic [WORD_W-1:0] r_tap;
    logic [WORD_W-1:0] n_tap;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (IDX > i_pos) begin
                    n_data = i_left;
                end else if (IDX == i_pos) begin
                    n_data = i_word;
                end
            end
            CELL_REMOVE: begin
                if (IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            CELL_WRITE: begin
                if (IDX == i_pos) begin
                    n_data = i_word;
                end
            end
            default: begin
            end
        endcase
    end

    // offer the word held before this step; zero when not addressed
    assign n_tap = (i_ctrl.rd && (IDX == i_pos)) ? r_data : '0;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule
`default_nettype wire

// ===== sv/plist_group.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plist_group
// One registered level of the read-back tree: OR of a group of taps.
// ----------------------------------------------------------------------------
module plist_group #(
    parameter int N      = 8,
    parameter int WORD_W = 32
) (
    input  wire                     i_clk,
    input  wire  [N-1:0][WORD_W-1:0] i_data,
    output logic [WORD_W-1:0]       o_data
);
    logic [WORD_W-1:0] r_or;
    logic [WORD_W-1:0] n_or;

    always_comb begin
        n_or = '0;
        for (int k = 0; k < N; k++) begin
            n_or = n_or | i_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_or <= n_or;
    end

    assign o_data = r_or;

endmodule
`default_nettype wire

// ===== sv/positional_list_insert_remove.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Bounded ordered list of words addressed by position, built as a chain of
// shifting cells with a registered read-back tree.
// ----------------------------------------------------------------------------
// An item is accepted in the idle cycle, where the request is checked against
// the current count. The cycle after acceptance steps the whole cell chain in
// parallel (shift, write or hold) and latches the addressed cell's old word on
// its tap. Two registered OR levels then collect that word, and the result is
// loaded into the output register in the done state. The input is ready again
// in the cycle after that load, so no new item is taken while one is in
// flight. A result still waiting in the output register holds the next
// finished item in its last stage, with its read word kept aside, and delays
// the acceptance that follows by the length of the stall. Refused requests
// (bad position, full, empty) leave the list untouched and return zero data.
// Entries beyond the count hold stale words and are never returned.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
    parameter int CAPACITY   = plist_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = plist_pkg::WORD_WIDTH_DEF,
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  plist_pkg::t_opcode      i_opcode,
    input  wire  [CNT_W-1:0]        i_position,
    input  wire  [WORD_WIDTH-1:0]   i_data_in,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [WORD_WIDTH-1:0]   o_data_out,
    output logic [CNT_W-1:0]        o_count_out,
    output plist_pkg::t_status      o_status
);
    import plist_pkg::*;

    localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD    = NGROUP * GROUP_SIZE;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // sequencer
    t_state r_state;
    t_state n_state;

    // held request
    t_cell_op          r_cmd;
    t_cell_op          n_cmd;
    logic              r_rd;
    logic              n_rd;
    t_status           r_req_status;
    t_status           n_req_status;
    logic [CNT_W-1:0]  r_pos;
    logic [WORD_WIDTH-1:0] r_word;

    // list length
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // output register
    logic                  r_out_valid;
    logic [WORD_WIDTH-1:0] r_data_out;
    logic [CNT_W-1:0]      r_count_out;
    t_status               r_status;

    // read word kept while the output register is still occupied
    logic                  r_read_fresh;
    logic [WORD_WIDTH-1:0] r_read_hold;
    logic [WORD_WIDTH-1:0] result_word;

    logic       in_accept;
    logic       load_out;
    t_cell_ctrl cell_ctrl;

    logic [CAPACITY-1:0][WORD_WIDTH-1:0] cell_data;
    logic [PAD-1:0][WORD_WIDTH-1:0]      taps;
    logic [NGROUP-1:0][WORD_WIDTH-1:0]   grp_or;
    logic [WORD_WIDTH-1:0]               read_word;

    assign in_accept = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------- decode
    // Check the request against the current count and pick the cell action.
    // A set at the end of the list appends, which is an insert at the count.
    always_comb begin
        n_cmd        = CELL_HOLD;
        n_rd         = 1'b0;
        n_req_status = ST_OK;
        unique case (i_opcode)
            OP_INSERT: begin
                if (i_position > r_count) begin
                    n_req_status = ST_RANGE;
                end else if (r_count == CAP_C) begin
                    n_req_status = ST_FULL;
                end else begin
                    n_cmd = CELL_INSERT;
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    n_req_status = ST_EMPTY;
                end else if (i_position >= r_count) begin
                    n_req_status = ST_RANGE;
                end else begin
                    n_cmd = CELL_REMOVE;
                    n_rd  = 1'b1;
                end
            end
            OP_GET: begin
                if (r_count == '0) begin
                    n_req_status = ST_EMPTY;
                end else if (i_position >= r_count) begin
                    n_req_status = ST_RANGE;
                end else begin
                    n_rd = 1'b1;
                end
            end
            OP_SET: begin
                if (i_position > r_count) begin
                    n_req_status = ST_RANGE;
                end else if (i_position == r_count) begin
                    if (r_count == CAP_C) begin
                        n_req_status = ST_FULL;
                    end else begin
                        n_cmd = CELL_INSERT;
                    end
                end else begin
                    n_cmd = CELL_WRITE;
                    n_rd  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pos  <= i_position;
            r_word <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CELL_HOLD;
            r_rd         <= 1'b0;
            r_req_status <= ST_OK;
        end else if (in_accept) begin
            r_cmd        <= n_cmd;
            r_rd         <= n_rd;
            r_req_status <= n_req_status;
        end
    end

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = S_GROUP;
            S_GROUP: n_state = S_MERGE;
            S_MERGE: n_state = S_DONE;
            S_DONE:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------- outputs
    // Drive the cells only in the step cycle; hold them everywhere else.
    always_comb begin
        o_in_ready   = 1'b0;
        load_out     = 1'b0;
        cell_ctrl.op = CELL_HOLD;
        cell_ctrl.rd = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_EXEC: begin
                cell_ctrl.op = r_cmd;
                cell_ctrl.rd = r_rd;
            end
            S_DONE: load_out = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // --------------------------------------------------------------- count
    always_comb begin
        n_count = r_count;
        case (cell_ctrl.op)
            CELL_INSERT: n_count = r_count + CNT_W'(1);
            CELL_REMOVE: n_count = r_count - CNT_W'(1);
            default:     n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ---------------------------------------------------------- cell chain
    // Cell k takes cell k-1 on insert and cell k+1 on remove; the ends see
    // zero, which only ever lands past the count.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_word;
        logic [WORD_WIDTH-1:0] right_word;

        if (k == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = cell_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = cell_data[k+1];
        end

        plist_cell #(
            .INDEX  (k),
            .CNT_W  (CNT_W),
            .WORD_W (WORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_pos   (r_pos),
            .i_word  (r_word),
            .i_left  (left_word),
            .i_right (right_word),
            .o_data  (cell_data[k]),
            .o_tap   (taps[k])
        );
    end

    // pad the last group with zero taps
    for (genvar k = CAPACITY; k < PAD; k++) begin : g_pad
        assign taps[k] = '0;
    end

    // ------------------------------------------------------ read-back tree
    for (genvar g = 0; g < NGROUP; g++) begin : g_grp
        plist_group #(
            .N      (GROUP_SIZE),
            .WORD_W (WORD_WIDTH)
        ) u_grp (
            .i_clk  (i_clk),
            .i_data (taps[g*GROUP_SIZE +: GROUP_SIZE]),
            .o_data (grp_or[g])
        );
    end

    plist_group #(
        .N      (NGROUP),
        .WORD_W (WORD_WIDTH)
    ) u_merge (
        .i_clk  (i_clk),
        .i_data (grp_or),
        .o_data (read_word)
    );

    // The tree output is valid only in the first done cycle; keep a copy
    // for as long as the output register stays occupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_fresh <= 1'b0;
        end else begin
            r_read_fresh <= (r_state == S_MERGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_read_fresh) begin
            r_read_hold <= read_word;
        end
    end

    assign result_word = r_read_fresh ? read_word : r_read_hold;

    // ------------------------------------------------------ output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_data_out  <= result_word;
            r_count_out <= r_count;
            r_status    <= r_req_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_count_out = r_count_out;
    assign o_status    = r_status;

    // ---------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("list count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_ctrl.op == CELL_INSERT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count by one");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_req_status != ST_OK) |=> (r_data_out == '0))
        else $error("refused request returned nonzero data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (!o_in_ready && r_state == S_EXEC))
        else $error("second item accepted while one is in flight");

endmodule
`default_nettype wire

// ===== tb/positional_list_insert_remove_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_tb
// Self-checking bench for the positional list. A shadow list inside the
// bench predicts every result: requests are pushed into a queue of expected
// results at the input handshake, and each output item is compared with the
// oldest entry field by field. Directed probes cover the empty, full and
// out-of-range refusals; random sequences walk the list between empty and
// full under random idling on both sides.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_tb;
    import plist_pkg::*;

    localparam int LIST_DEPTH  = CAPACITY_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [31:0] data;
        logic [6:0]  count;
        t_status     status;
    } t_list_result;

    // DUT ports; every input starts at a known value
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_opcode     i_opcode    = OP_GET;
    logic [6:0]  i_position  = '0;
    logic [31:0] i_data_in   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_data_out;
    logic [6:0]  o_count_out;
    t_status     o_status;

    // shadow list and pending results
    logic [31:0]  list_words [LIST_DEPTH];
    int unsigned  list_count;
    t_list_result pending_results [$];

    // run bookkeeping
    bit          idle_en = 1'b1;
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned items_per_op [4];
    int unsigned results_per_status [4];
    int unsigned stall_cycles;

    positional_list_insert_remove u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_count_out (o_count_out),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Open a slot at pos and store the word there; later entries move up.
    function automatic void list_place(int unsigned pos, logic [31:0] word);
        int unsigned k;
        for (k = list_count; k > pos; k--) begin
            list_words[k] = list_words[k - 1];
        end
        list_words[pos] = word;
        list_count++;
    endfunction

    // Apply one request to the shadow list and return the result it causes.
    // Refused requests leave the list untouched and return zero data.
    function automatic t_list_result apply_request(t_opcode op, logic [6:0] pos,
                                                   logic [31:0] word);
        t_list_result res;
        int unsigned  k;
        res.data   = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (pos > list_count) begin
                    res.status = ST_RANGE;
                end else if (list_count >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_place(pos, word);
                end
            end
            OP_REMOVE: begin
                // empty is checked before the position
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = list_words[pos];
                    for (k = pos; k + 1 < list_count; k++) begin
                        list_words[k] = list_words[k + 1];
                    end
                    list_count--;
                end
            end
            OP_GET: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = list_words[pos];
                end
            end
            default: begin
                // set at the count appends; below it the old word comes back
                if (pos > list_count) begin
                    res.status = ST_RANGE;
                end else if (pos == list_count) begin
                    if (list_count >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        list_place(pos, word);
                    end
                end else begin
                    res.data        = list_words[pos];
                    list_words[pos] = word;
                end
            end
        endcase
        res.count = list_count[6:0];
        return res;
    endfunction

    // Send one item. Called right after a rising edge; returns at the edge
    // that accepted the item, with valid still high so a following item
    // can go straight out without a gap.
    task automatic send_item(t_opcode op, logic [6:0] pos, logic [31:0] word);
        t_list_result res;
        // drop valid for a random gap while idling is on
        while (idle_en && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_data_in  <= word;
        // hold the item until the block takes it
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = apply_request(op, pos, word);
        pending_results.push_back(res);
        items_per_op[op]++;
        results_per_status[res.status]++;
    endtask

    // Lower valid and hold off until every pending result has arrived.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick an in-range position for the given operation; an empty list still gets zero.
    function automatic logic [6:0] legal_position(t_opcode op);
        if (op == OP_INSERT) return 7'($urandom_range(list_count));
        if (op == OP_SET && $urandom_range(3) == 0) return 7'(list_count);
        if (list_count == 0) return 7'd0;
        return 7'($urandom_range(list_count - 1));
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Probe every refusal on the empty list, build a short list with the
    // data extremes, read it back, and remove two of its entries again.
    task automatic test_directed();
        send_item(OP_GET,    7'd0,   32'h0000_0000);
        send_item(OP_REMOVE, 7'd0,   32'h0000_0000);
        send_item(OP_GET,    7'd127, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 7'd64,  32'h0000_0000);
        send_item(OP_INSERT, 7'd1,   32'hDEAD_BEEF);
        send_item(OP_SET,    7'd1,   32'hDEAD_BEEF);
        send_item(OP_INSERT, 7'd0,   32'h0000_0000);
        send_item(OP_INSERT, 7'd1,   32'hFFFF_FFFF);
        send_item(OP_INSERT, 7'd1,   32'hA5A5_A5A5);
        send_item(OP_SET,    7'd3,   32'h5A5A_5A5A);
        send_item(OP_SET,    7'd0,   32'h1234_5678);
        send_item(OP_GET,    7'd0,   32'h0000_0000);
        send_item(OP_GET,    7'd1,   32'h0000_0000);
        send_item(OP_GET,    7'd2,   32'h0000_0000);
        send_item(OP_GET,    7'd3,   32'h0000_0000);
        send_item(OP_GET,    7'd4,   32'h0000_0000);
        send_item(OP_REMOVE, 7'd4,   32'h0000_0000);
        send_item(OP_INSERT, 7'd5,   32'hFFFF_FFFF);
        send_item(OP_SET,    7'd5,   32'hFFFF_FFFF);
        send_item(OP_INSERT, 7'd127, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 7'd1,   32'h0000_0000);
        send_item(OP_REMOVE, 7'd0,   32'h0000_0000);
        send_item(OP_GET,    7'd0,   32'h0000_0000);
    endtask

    // Fill to capacity at random positions, probe the full and out-of-range
    // refusals, then drain at random positions and probe the empty refusal.
    task automatic test_fill_and_drain();
        while (list_count < LIST_DEPTH) begin
            send_item(OP_INSERT, legal_position(OP_INSERT), $urandom());
        end
        send_item(OP_INSERT, 7'd0,  $urandom());
        send_item(OP_INSERT, 7'd64, $urandom());
        send_item(OP_SET,    7'd64, $urandom());
        send_item(OP_INSERT, 7'd65, $urandom());
        send_item(OP_SET,    7'd65, $urandom());
        send_item(OP_GET,    7'd63, $urandom());
        send_item(OP_GET,    7'd64, $urandom());
        send_item(OP_REMOVE, 7'd64, $urandom());
        send_item(OP_SET,    7'($urandom_range(63)), $urandom());
        while (list_count > 0) begin
            send_item(OP_REMOVE, legal_position(OP_REMOVE), $urandom());
        end
        send_item(OP_REMOVE, 7'd0, $urandom());
    endtask

    // Mostly well-formed requests with random content; grow_pct sets the
    // drift toward full, and a tenth of the items are raw noise.
    task automatic test_random_mix(int unsigned n_items, int unsigned grow_pct);
        int unsigned i;
        int unsigned pick;
        t_opcode     op;
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                op = t_opcode'($urandom_range(3));
                send_item(op, 7'($urandom_range(127)), $urandom());
            end else begin
                if (pick < 10 + grow_pct) begin
                    op = ($urandom_range(3) == 0) ? OP_SET : OP_INSERT;
                end else if (pick < 70) begin
                    op = OP_REMOVE;
                end else begin
                    op = ($urandom_range(1) == 0) ? OP_GET : OP_SET;
                end
                // an append by set needs the position to equal the count
                if (op == OP_SET && pick < 10 + grow_pct) begin
                    send_item(op, 7'(list_count), $urandom());
                end else begin
                    send_item(op, legal_position(op), $urandom());
                end
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        test_random_mix(200, 30);
        idle_en = 1'b1;
    endtask

    // Bursts separated by pauses in which the sender holds off until the
    // output side has caught up.
    task automatic test_pressure();
        int unsigned burst;
        for (burst = 0; burst < 4; burst++) begin
            test_random_mix(40, 30);
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: data %h count %0d status %s",
                         $time, o_data_out, o_count_out, o_status.name());
                mismatch_count++;
            end else begin
                results_checked++;
                if (o_data_out !== pending_results[0].data) begin
                    $display("%0t: data_out expected %h actual %h", $time,
                             pending_results[0].data, o_data_out);
                    mismatch_count++;
                end
                if (o_count_out !== pending_results[0].count) begin
                    $display("%0t: count_out expected %0d actual %0d", $time,
                             pending_results[0].count, o_count_out);
                    mismatch_count++;
                end
                if (o_status !== pending_results[0].status) begin
                    $display("%0t: status expected %s actual %s", $time,
                             pending_results[0].status.name(), o_status.name());
                    mismatch_count++;
                end
                void'(pending_results.pop_front());
            end
        end
        // stall with a chance of about one in six while idling is on
        i_out_ready <= idle_en ? ($urandom_range(99) >= 16) : 1'b1;
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        list_count = 0;
        foreach (list_words[k]) list_words[k] = '0;
        // hold reset at the start, then release it once for the whole run
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix(300, 45);
        test_random_mix(300, 15);
        test_back_to_back();
        test_pressure();

        // drain: drop valid, wait out every pending result, then settle
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d inserts, %0d removes, %0d gets, %0d sets; %0d results checked.",
                 items_per_op[OP_INSERT], items_per_op[OP_REMOVE],
                 items_per_op[OP_GET], items_per_op[OP_SET], results_checked);
        $display("Outcomes: %0d ok, %0d out of range, %0d full, %0d empty.",
                 results_per_status[ST_OK], results_per_status[ST_RANGE],
                 results_per_status[ST_FULL], results_per_status[ST_EMPTY]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
